/* rtl/gasc_pkg.sv */
// ----------------------------------------------------------------------------
// gasc_pkg
// Shared types, widths and helpers of the glyph atlas slot cache.
// ----------------------------------------------------------------------------
package gasc_pkg;

    // Parameter defaults
    localparam int MAP_DEPTH_DEF = 4096;
    localparam int MAX_ATLAS_DEF = 8192;
    localparam int MAX_SLOTS_DEF = 65536;

    // Field widths
    localparam int REQ_W      = 2;
    localparam int CODE_W     = 21;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 16;
    localparam int COORD_W    = 13;
    localparam int SIDE_W     = 14;
    localparam int TILE_W     = 9;
    localparam int NEXT_W     = 17;
    localparam int EPOCH_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    // Divider geometry
    localparam int DIV_N = 16;
    localparam int DIV_D = SIDE_W;

    // Reset values
    localparam logic [TILE_W-1:0]  TILE_RESET = 9'd8;
    localparam logic [TILE_W-1:0]  TILE_MAX   = 9'd256;
    localparam logic [SIDE_W-1:0]  SIDE_RESET = 14'd256;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX  = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ENSURE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_SIZE  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT     = 3'd0,
        ST_PLACED  = 3'd1,
        ST_GROWN   = 3'd2,
        ST_CLEARED = 3'd3,
        ST_ABSENT  = 3'd4,
        ST_RANGE   = 3'd5,
        ST_NOGROW  = 3'd6
    } gasc_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_COLS_GO,
        S_COLS_WAIT,
        S_ROWS_GO,
        S_ROWS_WAIT,
        S_CAP,
        S_LOOK,
        S_SLOT_GO,
        S_SLOT_WAIT,
        S_RECT,
        S_FIN
    } gasc_state_t;

    typedef enum logic [1:0] {
        DIV_COLS,
        DIV_ROWS,
        DIV_SLOT
    } gasc_div_op_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_HIT,
        SRC_NEXT
    } gasc_slot_src_t;

    // Controller to datapath
    typedef struct packed {
        logic           load_req;
        logic           pass_write;
        logic           div_start;
        gasc_div_op_t   div_op;
        logic           cols_load;
        logic           rows_load;
        logic           cap_load;
        logic           res_load;
        gasc_status_t   res_status;
        gasc_slot_src_t slot_src;
        logic           place;
        logic           map_clear;
        logic           grow;
        logic           rect_load;
        logic           out_load;
    } gasc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic pass_last;
        logic out_free;
        logic req_clear;
        logic req_ensure;
        logic code_oor;
        logic hit;
        logic full;
        logic can_grow;
        logic cols_zero;
        logic cfg_geom;
        logic epoch_wrap;
    } gasc_stat_t;

    // Tile sizes are used in the range 1..256
    function automatic logic [TILE_W-1:0] clamp_tile(input logic [TILE_W-1:0] v);
        logic [TILE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = 9'd1;
        end
        else if (v > TILE_MAX) begin
            r = TILE_MAX;
        end
        return r;
    endfunction

endpackage

/* rtl/gasc_ram.sv */
// ----------------------------------------------------------------------------
// gasc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gasc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/gasc_div.sv */
// ----------------------------------------------------------------------------
// gasc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gasc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gasc_pkg::DIV_N-1:0] dividend,
    input  logic [gasc_pkg::DIV_D-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [gasc_pkg::DIV_N-1:0] quotient,
    output logic [gasc_pkg::DIV_D-1:0] remainder
);
    import gasc_pkg::*;

    localparam int CNT_W = $clog2(DIV_N);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N - 1);

    logic [DIV_N-1:0] q_reg, q_next;
    logic [DIV_D-1:0] r_reg, r_next;
    logic [DIV_D-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_D:0]   trial;
    logic [DIV_D:0]   diff;
    logic             ge;

    // One restoring step
    always_comb
    begin
        trial = {r_reg, q_reg[DIV_N-1]};
        diff  = trial - {1'b0, d_reg};
        ge    = (trial >= {1'b0, d_reg});
    end

    // Step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[DIV_N-2:0], ge};
            r_next = ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

/* rtl/gasc_dp.sv */
// ----------------------------------------------------------------------------
// gasc_dp
// Datapath: registers, slot map memory, divider, rectangle math, output item.
// ----------------------------------------------------------------------------
module gasc_dp #(
    parameter int MAP_DEPTH      = gasc_pkg::MAP_DEPTH_DEF,
    parameter int MAX_ATLAS_SIZE = gasc_pkg::MAX_ATLAS_DEF,
    parameter int MAX_SLOTS      = gasc_pkg::MAX_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gasc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gasc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [gasc_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [gasc_pkg::REQ_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gasc_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [gasc_pkg::STATUS_W-1:0]       m_tuser,
    input  gasc_pkg::gasc_cmd_t                 cmd,
    output gasc_pkg::gasc_stat_t                stat
);
    import gasc_pkg::*;

    localparam int AW     = $clog2(MAP_DEPTH);
    localparam int RAM_W  = EPOCH_W + SLOT_W;
    localparam int XP_W   = SIDE_W + TILE_W;
    localparam int YP_W   = DIV_N + TILE_W;
    localparam int CP_W   = 2 * SIDE_W;
    localparam logic [AW-1:0]       PASS_LAST = AW'(MAP_DEPTH - 1);
    localparam logic [CODE_W-1:0]   CODE_LIM  = CODE_W'(MAP_DEPTH);
    localparam logic [SIDE_W-1:0]   SIDE_MAX  = SIDE_W'(MAX_ATLAS_SIZE);
    localparam logic [SIDE_W:0]     DBL_MAX   = (SIDE_W + 1)'(MAX_ATLAS_SIZE);
    localparam logic [CP_W-1:0]     CAP_LIM   = CP_W'(MAX_SLOTS);
    localparam logic [NEXT_W-1:0]   CAP_SAT   = NEXT_W'(MAX_SLOTS);

    // Control state
    logic [TILE_W-1:0]  tile_w_reg, tile_w_next;
    logic [TILE_W-1:0]  tile_h_reg, tile_h_next;
    logic [SIDE_W-1:0]  atlas_side_reg, atlas_side_next;
    logic [NEXT_W-1:0]  next_slot_reg, next_slot_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [AW-1:0]      pass_cnt_reg, pass_cnt_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Payload
    logic [REQ_W-1:0]      req_reg;
    logic [CODE_W-1:0]     code_reg;
    logic [SIDE_W-1:0]     cols_reg;
    logic [SIDE_W-1:0]     rows_reg;
    logic [NEXT_W-1:0]     cap_reg;
    gasc_status_t          res_status_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic [COORD_W-1:0]    res_x_reg;
    logic [COORD_W-1:0]    res_y_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]   m_tuser_reg;

    logic [TILE_W-1:0]  tw_used;
    logic [TILE_W-1:0]  th_used;
    logic               cfg_size_wr;
    logic               map_clr;
    logic [SIDE_W-1:0]  side_clamped;
    logic [SIDE_W-1:0]  cfg_side;
    logic [EPOCH_W-1:0] epoch_step;

    logic [DIV_N-1:0]   div_dividend;
    logic [DIV_D-1:0]   div_divisor;
    logic               div_busy;
    logic               div_done;
    logic [DIV_N-1:0]   div_quot;
    logic [DIV_D-1:0]   div_rem;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [RAM_W-1:0]   ram_wdata;
    logic [RAM_W-1:0]   ram_rdata;

    logic [XP_W-1:0]    x_prod;
    logic [YP_W-1:0]    y_prod;
    logic [CP_W-1:0]    cap_prod;
    logic [NEXT_W-1:0]  cap_next;
    logic [SIDE_W:0]    side_dbl;

    assign tw_used = clamp_tile(tile_w_reg);
    assign th_used = clamp_tile(tile_h_reg);

    // Decode register writes; an atlas size write clears the map
    assign cfg_size_wr = cfg_we && (cfg_index == CFG_ATLAS_SIZE);
    assign map_clr     = cmd.map_clear || cfg_size_wr;
    assign cfg_side    = cfg_data[SIDE_W-1:0];

    always_comb
    begin
        side_clamped = cfg_side;
        if (cfg_side == '0)
        begin
            side_clamped = 14'd1;
        end
        else if (cfg_side > SIDE_MAX)
        begin
            side_clamped = SIDE_MAX;
        end
    end

    // Skip epoch zero, which marks swept entries
    assign epoch_step = (epoch_reg == EPOCH_MAX) ? EPOCH_FIRST : epoch_reg + 1'b1;

    always_comb
    begin
        tile_w_next = tile_w_reg;
        tile_h_next = tile_h_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TILE_WIDTH:  tile_w_next = cfg_data[TILE_W-1:0];
                CFG_TILE_HEIGHT: tile_h_next = cfg_data[TILE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Atlas side, allocation pointer and epoch
    always_comb
    begin
        atlas_side_next = atlas_side_reg;
        next_slot_next  = next_slot_reg;
        epoch_next      = epoch_reg;
        if (cfg_size_wr)
        begin
            atlas_side_next = side_clamped;
        end
        else if (cmd.grow)
        begin
            atlas_side_next = {atlas_side_reg[SIDE_W-2:0], 1'b0};
        end
        if (map_clr)
        begin
            next_slot_next = '0;
            epoch_next     = epoch_step;
        end
        else if (cmd.place)
        begin
            next_slot_next = next_slot_reg + 1'b1;
        end
    end

    // Sweep address
    always_comb
    begin
        pass_cnt_next = pass_cnt_reg;
        if (cmd.pass_write)
        begin
            pass_cnt_next = (pass_cnt_reg == PASS_LAST) ? '0 : pass_cnt_reg + 1'b1;
        end
    end

    // Output item register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_w_reg     <= TILE_RESET;
            tile_h_reg     <= TILE_RESET;
            atlas_side_reg <= SIDE_RESET;
            next_slot_reg  <= '0;
            epoch_reg      <= EPOCH_FIRST;
            pass_cnt_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            tile_w_reg     <= tile_w_next;
            tile_h_reg     <= tile_h_next;
            atlas_side_reg <= atlas_side_next;
            next_slot_reg  <= next_slot_next;
            epoch_reg      <= epoch_next;
            pass_cnt_reg   <= pass_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Divider operand select
    always_comb
    begin
        case (cmd.div_op)
            DIV_COLS:
            begin
                div_dividend = DIV_N'(atlas_side_reg);
                div_divisor  = DIV_D'(tw_used);
            end
            DIV_ROWS:
            begin
                div_dividend = DIV_N'(atlas_side_reg);
                div_divisor  = DIV_D'(th_used);
            end
            default:
            begin
                div_dividend = res_slot_reg;
                div_divisor  = cols_reg;
            end
        endcase
    end

    gasc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Slot map: each entry holds the epoch it was written in and its slot
    assign ram_we    = cmd.pass_write || cmd.place;
    assign ram_waddr = cmd.pass_write ? pass_cnt_reg : code_reg[AW-1:0];
    assign ram_wdata = cmd.pass_write ? '0 : {epoch_reg, next_slot_reg[SLOT_W-1:0]};

    gasc_ram #(
        .WIDTH  (RAM_W),
        .DEPTH  (MAP_DEPTH),
        .ADDR_W (AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.load_req),
        .raddr (s_tdata[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Rectangle and capacity products
    assign x_prod   = XP_W'(div_rem) * XP_W'(tw_used);
    assign y_prod   = YP_W'(div_quot) * YP_W'(th_used);
    assign cap_prod = CP_W'(cols_reg) * CP_W'(rows_reg);
    assign cap_next = (cap_prod > CAP_LIM) ? CAP_SAT : cap_prod[NEXT_W-1:0];

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg  <= s_tuser;
            code_reg <= s_tdata[CODE_W-1:0];
        end
        if (cmd.cols_load)
        begin
            cols_reg <= div_quot[SIDE_W-1:0];
        end
        if (cmd.rows_load)
        begin
            rows_reg <= div_quot[SIDE_W-1:0];
        end
        if (cmd.cap_load)
        begin
            cap_reg <= cap_next;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            case (cmd.slot_src)
                SRC_HIT:  res_slot_reg <= ram_rdata[SLOT_W-1:0];
                SRC_NEXT: res_slot_reg <= next_slot_reg[SLOT_W-1:0];
                default:  res_slot_reg <= '0;
            endcase
        end
        if (cmd.rect_load)
        begin
            res_x_reg <= x_prod[COORD_W-1:0];
            res_y_reg <= y_prod[COORD_W-1:0];
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {atlas_side_reg, res_y_reg, res_x_reg, res_slot_reg};
            m_tuser_reg <= res_status_reg;
        end
    end

    // Status toward the controller
    assign side_dbl = {atlas_side_reg, 1'b0};

    always_comb
    begin
        stat            = '0;
        stat.div_busy   = div_busy;
        stat.div_done   = div_done;
        stat.pass_last  = (pass_cnt_reg == PASS_LAST);
        stat.out_free   = !m_tvalid_reg || m_tready;
        stat.req_clear  = (req_reg == REQ_RESET);
        stat.req_ensure = (req_reg == REQ_ENSURE);
        stat.code_oor   = (code_reg >= CODE_LIM);
        stat.hit        = (ram_rdata[RAM_W-1:SLOT_W] == epoch_reg);
        stat.full       = (next_slot_reg >= cap_reg);
        stat.can_grow   = (side_dbl <= DBL_MAX);
        stat.cols_zero  = (cols_reg == '0);
        stat.cfg_geom   = cfg_we && (cfg_index == CFG_TILE_WIDTH ||
                                     cfg_index == CFG_TILE_HEIGHT ||
                                     cfg_index == CFG_ATLAS_SIZE);
        stat.epoch_wrap = map_clr && (epoch_reg == EPOCH_MAX);
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/gasc_ctrl.sv */
// ----------------------------------------------------------------------------
// gasc_ctrl
// Controller: sweeps the map, refreshes geometry and sequences each request.
// ----------------------------------------------------------------------------
module gasc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  gasc_pkg::gasc_stat_t stat,
    output gasc_pkg::gasc_cmd_t  cmd
);
    import gasc_pkg::*;

    gasc_state_t state_reg, state_next;
    logic        pass_pend_reg, pass_pend_next;
    logic        dirty_reg, dirty_next;
    logic        ready;

    assign ready = (state_reg == S_IDLE) && !pass_pend_reg && !dirty_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pass_pend_reg)
                begin
                    state_next = S_CLEAR;
                end
                else if (dirty_reg)
                begin
                    state_next = S_COLS_GO;
                end
                else if (s_tvalid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_CLEAR:
            begin
                if (stat.pass_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_COLS_GO:   state_next = S_COLS_WAIT;
            S_COLS_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_ROWS_GO;
                end
            end
            S_ROWS_GO:   state_next = S_ROWS_WAIT;
            S_ROWS_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_CAP;
                end
            end
            S_CAP:       state_next = S_IDLE;
            S_LOOK:
            begin
                state_next = S_FIN;
                if (!stat.req_clear && !stat.code_oor && !stat.cols_zero)
                begin
                    if (stat.hit || (stat.req_ensure && !stat.full))
                    begin
                        state_next = S_SLOT_GO;
                    end
                end
            end
            S_SLOT_GO:   state_next = S_SLOT_WAIT;
            S_SLOT_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_RECT;
                end
            end
            S_RECT:      state_next = S_FIN;
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready     = ready;
                cmd.load_req = ready && s_tvalid;
            end
            S_CLEAR:
            begin
                cmd.pass_write = 1'b1;
            end
            S_COLS_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_COLS;
            end
            S_COLS_WAIT:
            begin
                cmd.cols_load = stat.div_done;
            end
            S_ROWS_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_ROWS;
            end
            S_ROWS_WAIT:
            begin
                cmd.rows_load = stat.div_done;
            end
            S_CAP:
            begin
                cmd.cap_load = 1'b1;
            end
            S_LOOK:
            begin
                cmd.res_load = 1'b1;
                if (stat.req_clear)
                begin
                    cmd.res_status = ST_CLEARED;
                    cmd.map_clear  = 1'b1;
                end
                else if (stat.code_oor)
                begin
                    cmd.res_status = ST_RANGE;
                end
                else if (stat.hit)
                begin
                    cmd.res_status = ST_HIT;
                    cmd.slot_src   = SRC_HIT;
                end
                else if (!stat.req_ensure)
                begin
                    cmd.res_status = ST_ABSENT;
                end
                else if (stat.full)
                begin
                    if (stat.can_grow)
                    begin
                        cmd.res_status = ST_GROWN;
                        cmd.grow       = 1'b1;
                        cmd.map_clear  = 1'b1;
                    end
                    else
                    begin
                        cmd.res_status = ST_NOGROW;
                    end
                end
                else
                begin
                    cmd.res_status = ST_PLACED;
                    cmd.slot_src   = SRC_NEXT;
                    cmd.place      = 1'b1;
                end
            end
            S_SLOT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_SLOT;
            end
            S_SLOT_WAIT:
            begin
                cmd.div_op = DIV_SLOT;
            end
            S_RECT:
            begin
                cmd.rect_load = 1'b1;
            end
            S_FIN:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Pending sweep and stale geometry flags
    always_comb
    begin
        pass_pend_next = pass_pend_reg;
        dirty_next     = dirty_reg;
        if (state_reg == S_IDLE && pass_pend_reg)
        begin
            pass_pend_next = 1'b0;
        end
        if (stat.epoch_wrap)
        begin
            pass_pend_next = 1'b1;
        end
        if (state_reg == S_COLS_GO)
        begin
            dirty_next = 1'b0;
        end
        if (stat.cfg_geom || cmd.grow)
        begin
            dirty_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_pend_reg <= 1'b1;
            dirty_reg     <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            pass_pend_reg <= pass_pend_next;
            dirty_reg     <= dirty_next;
        end
    end

endmodule

/* rtl/glyph_atlas_slot_cache.sv */
// ----------------------------------------------------------------------------
// glyph_atlas_slot_cache
// Maps character codes to slots and pixel rectangles of a square glyph atlas.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_* stream (tuser = request kind, tdata = code).
//   Every request returns exactly one item on the m_* stream (tuser = status,
//   tdata = slot, rectangle and current atlas side). Registers are written
//   through cfg_we/cfg_index/cfg_data while no request is outstanding.
//   A hit or a new placement passes through the shared restoring divider
//   (slot / columns) when the column count is nonzero; other outcomes skip
//   it. One request is worked at a time: the next is accepted only once the
//   last one has reached the output register.
//   After reset, and after every 255th map clear, a sweep rewrites all
//   MAP_DEPTH map entries (4096 by default); after reset, columns, rows and
//   capacity are then recomputed. s_tready is low meanwhile. The same
//   recompute follows a tile or atlas size write and a growth. Other clears
//   only advance an epoch mark and cost nothing.
//   A finished item waits in the output register while m_tready is low; the
//   next request is still accepted and works up to that point.
// ----------------------------------------------------------------------------
module glyph_atlas_slot_cache #(
    parameter int MAP_DEPTH      = gasc_pkg::MAP_DEPTH_DEF,
    parameter int MAX_ATLAS_SIZE = gasc_pkg::MAX_ATLAS_DEF,
    parameter int MAX_SLOTS      = gasc_pkg::MAX_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gasc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gasc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gasc_pkg::IN_DATA_W-1:0]  s_tdata,   // codepoint[20:0], zero pad
    input  logic [gasc_pkg::REQ_W-1:0]      s_tuser,   // req_type[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gasc_pkg::OUT_DATA_W-1:0] m_tdata,   // slot_index[15:0],
                                                       // rect_x[28:16], rect_y[41:29],
                                                       // atlas_size[55:42]
    output logic [gasc_pkg::STATUS_W-1:0]   m_tuser    // status[2:0]
);
    import gasc_pkg::*;

    gasc_cmd_t  cmd;
    gasc_stat_t stat;

    gasc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gasc_dp #(
        .MAP_DEPTH      (MAP_DEPTH),
        .MAX_ATLAS_SIZE (MAX_ATLAS_SIZE),
        .MAX_SLOTS      (MAX_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

    // One request in flight: no second accept right after the first
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // Never overwrite an output item that has not been taken
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output item overwritten before it was taken");

    // Divider is idle whenever a new divide is started
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divide started while divider busy");

    // Map sweep and slot placement never share the write port
    a_map_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.pass_write && cmd.place))
        else $error("map sweep and placement collide");

endmodule

/* test/tb_glyph_atlas_slot_cache.sv */
// ----------------------------------------------------------------------------
// tb_glyph_atlas_slot_cache
// Self-checking bench for the glyph atlas slot cache. A table of directed
// requests and register writes runs first, then phases of random requests
// under different tile and atlas geometries. Every accepted request is run
// through a behavioral slot allocator in the bench; each returned item is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_glyph_atlas_slot_cache;

    timeunit 1ns;
    timeprecision 1ps;

    import gasc_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 800000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned IDLE_PCT     = 23;
    localparam int unsigned SPARE_PCT    = 2;
    localparam int unsigned CODE_MAX     = 21'h1FFFFF;

    // Request kind 3 has no meaning of its own; the block treats it as a query
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    typedef struct packed {
        gasc_status_t       status;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] px_x;
        logic [COORD_W-1:0] px_y;
        logic [SIDE_W-1:0]  side;
    } glyph_t;

    // One row of the directed table: a register write or a request
    typedef struct packed {
        logic               is_cfg;
        logic [1:0]         sel;
        logic [CODE_W-1:0]  val;
        logic               typed;
        gasc_status_t       st;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] px_x;
        logic [COORD_W-1:0] px_y;
        logic [SIDE_W-1:0]  side;
    } dir_row_t;

    // Random phase: registers to write (bit 0 width, 1 height, 2 atlas), then mix
    typedef struct packed {
        logic [2:0]             wmask;
        logic [CFG_DATA_W-1:0]  tw;
        logic [CFG_DATA_W-1:0]  th;
        logic [CFG_DATA_W-1:0]  side;
        int unsigned            items;
        int unsigned            window;
        int unsigned            ens_pct;
        int unsigned            rst_pct;
        int unsigned            oor_pct;
    } phase_t;

    localparam int DIR_N = 25;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{1'b0, REQ_QUERY,  21'd0,       1'b1, ST_ABSENT,  16'd0, 13'd0, 13'd0, 14'd256},
        '{1'b0, REQ_ENSURE, 21'd0,       1'b1, ST_PLACED,  16'd0, 13'd0, 13'd0, 14'd256},
        '{1'b0, REQ_ENSURE, 21'd0,       1'b1, ST_HIT,     16'd0, 13'd0, 13'd0, 14'd256},
        '{1'b0, REQ_ENSURE, 21'd1,       1'b1, ST_PLACED,  16'd1, 13'd8, 13'd0, 14'd256},
        '{1'b0, REQ_ENSURE, 21'd4095,    1'b0, ST_HIT,     16'd0, 13'd0, 13'd0, 14'd0},
        '{1'b0, REQ_ENSURE, 21'd4096,    1'b1, ST_RANGE,   16'd0, 13'd0, 13'd0, 14'd256},
        '{1'b0, REQ_QUERY,  21'h1FFFFF,  1'b1, ST_RANGE,   16'd0, 13'd0, 13'd0, 14'd256},
        '{1'b0, REQ_SPARE,  21'd1,       1'b0, ST_HIT,     16'd0, 13'd0, 13'd0, 14'd0},
        '{1'b0, REQ_SPARE,  21'd77,      1'b0, ST_HIT,     16'd0, 13'd0, 13'd0, 14'd0},
        '{1'b0, REQ_QUERY,  21'd4095,    1'b0, ST_HIT,     16'd0, 13'd0, 13'd0, 14'd0},
        '{1'b0, REQ_RESET,  21'h1FFFFF,  1'b1, ST_CLEARED, 16'd0, 13'd0, 13'd0, 14'd256},
        '{1'b0, REQ_QUERY,  21'd0,       1'b1, ST_ABSENT,  16'd0, 13'd0, 13'd0, 14'd256},
        '{1'b0, REQ_ENSURE, 21'h0AAAAA,  1'b1, ST_RANGE,   16'd0, 13'd0, 13'd0, 14'd256},
        '{1'b0, REQ_ENSURE, 21'h155555,  1'b1, ST_RANGE,   16'd0, 13'd0, 13'd0, 14'd256},
        '{1'b0, REQ_ENSURE, 21'hAAA,     1'b0, ST_HIT,     16'd0, 13'd0, 13'd0, 14'd0},
        '{1'b0, REQ_ENSURE, 21'h555,     1'b0, ST_HIT,     16'd0, 13'd0, 13'd0, 14'd0},
        // tile width written with every data bit set: masked to 511, used as 256
        '{1'b1, CFG_TILE_WIDTH,  21'h3FFF, 1'b0, ST_HIT,   16'd0, 13'd0, 13'd0, 14'd0},
        '{1'b0, REQ_QUERY,  21'h555,     1'b0, ST_HIT,     16'd0, 13'd0, 13'd0, 14'd0},
        '{1'b1, CFG_TILE_HEIGHT, 21'd256,  1'b0, ST_HIT,   16'd0, 13'd0, 13'd0, 14'd0},
        // a single slot at side 256, already taken: full, so the atlas doubles
        '{1'b0, REQ_ENSURE, 21'd7,       1'b1, ST_GROWN,   16'd0, 13'd0, 13'd0, 14'd512},
        '{1'b0, REQ_ENSURE, 21'd7,       1'b1, ST_PLACED,  16'd0, 13'd0, 13'd0, 14'd512},
        // tile larger than the atlas: no capacity at all
        '{1'b1, CFG_ATLAS_SIZE,  21'd100,  1'b0, ST_HIT,   16'd0, 13'd0, 13'd0, 14'd0},
        '{1'b0, REQ_ENSURE, 21'd9,       1'b1, ST_GROWN,   16'd0, 13'd0, 13'd0, 14'd200},
        '{1'b0, REQ_ENSURE, 21'd9,       1'b0, ST_HIT,     16'd0, 13'd0, 13'd0, 14'd0},
        '{1'b0, REQ_ENSURE, 21'd9,       1'b0, ST_HIT,     16'd0, 13'd0, 13'd0, 14'd0}
    };

    localparam int PHASE_N  = 8;
    localparam int CALM_PH  = 3;
    localparam int PRESS_PH = 5;
    localparam phase_t PHASES [PHASE_N] = '{
        '{3'b111, 14'd16,    14'd24,    14'd64,    300, 64,   75, 10, 5},
        '{3'b111, 14'd1,     14'd1,     14'd3,     80,  8,    70, 0,  3},
        '{3'b001, 14'd256,   14'd0,     14'd0,     80,  8,    50, 0,  3},
        '{3'b111, 14'd1,     14'd1,     14'd64,    300, 512,  90, 0,  2},
        '{3'b011, 14'd64,    14'd256,   14'd0,     150, 512,  5,  0,  2},
        '{3'b111, 14'd256,   14'd256,   14'd4097,  450, 400,  92, 0,  2},
        '{3'b111, 14'd0,     14'h3FFF,  14'd0,     250, 300,  45, 45, 3},
        '{3'b111, 14'h3FFF,  14'd0,     14'h3FFF,  340, 4096, 45, 35, 3}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [REQ_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // Allocator state mirrored by the bench
    logic [SLOT_W-1:0] slot_of   [MAP_DEPTH_DEF];
    bit                slot_live [MAP_DEPTH_DEF];
    int unsigned       next_free;
    int unsigned       atlas_px;
    int unsigned       tile_w_reg;
    int unsigned       tile_h_reg;

    glyph_t      pending_glyphs [$];
    int unsigned mismatches  = 0;
    int unsigned results_in  = 0;
    int unsigned cycle_count = 0;
    bit          no_idle     = 1'b0;
    bit          hold_arm    = 1'b0;
    bit          hold_done   = 1'b0;
    int unsigned hold_left   = 0;

    glyph_atlas_slot_cache i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Tile sizes are used as 1..256, atlas sides as 1..MAX_ATLAS
    function automatic int unsigned eff_tile(int unsigned v);
        if (v == 0)
            return 1;
        if (v > 256)
            return 256;
        return v;
    endfunction

    function automatic int unsigned eff_side(int unsigned v);
        if (v == 0)
            return 1;
        if (v > MAX_ATLAS_DEF)
            return MAX_ATLAS_DEF;
        return v;
    endfunction

    function automatic void wipe_map();
        foreach (slot_live[i])
            slot_live[i] = 1'b0;
        next_free = 0;
    endfunction

    // Pixel rectangle of a slot; coordinates wrap to 13 bits
    function automatic glyph_t slot_rect(gasc_status_t st, logic [SLOT_W-1:0] slot,
                                         int unsigned cols);
        glyph_t      r;
        int unsigned px;
        int unsigned py;
        px = 0;
        py = 0;
        if (cols != 0)
        begin
            px = (slot % cols) * eff_tile(tile_w_reg);
            py = (slot / cols) * eff_tile(tile_h_reg);
        end
        r.status = st;
        r.slot   = slot;
        r.px_x   = px[COORD_W-1:0];
        r.px_y   = py[COORD_W-1:0];
        r.side   = '0;
        return r;
    endfunction

    // Work one request against the mirrored allocator and return its item
    function automatic glyph_t lookup_glyph(logic [REQ_W-1:0] req, logic [CODE_W-1:0] code);
        glyph_t      r;
        int unsigned cols;
        int unsigned cap;
        r    = '{status: ST_HIT, slot: '0, px_x: '0, px_y: '0, side: '0};
        cols = atlas_px / eff_tile(tile_w_reg);
        cap  = cols * (atlas_px / eff_tile(tile_h_reg));
        if (cap > MAX_SLOTS_DEF)
            cap = MAX_SLOTS_DEF;
        if (req == REQ_RESET)
        begin
            wipe_map();
            r.status = ST_CLEARED;
        end
        else if (code >= MAP_DEPTH_DEF)
            r.status = ST_RANGE;
        else if (slot_live[code[11:0]])
            r = slot_rect(ST_HIT, slot_of[code[11:0]], cols);
        else if (req != REQ_ENSURE)
            r.status = ST_ABSENT;
        else if (next_free >= cap)
        begin
            if (atlas_px * 2 > MAX_ATLAS_DEF)
                r.status = ST_NOGROW;
            else
            begin
                atlas_px = atlas_px * 2;
                wipe_map();
                r.status = ST_GROWN;
            end
        end
        else
        begin
            slot_of[code[11:0]]   = next_free[SLOT_W-1:0];
            slot_live[code[11:0]] = 1'b1;
            r = slot_rect(ST_PLACED, next_free[SLOT_W-1:0], cols);
            next_free = next_free + 1;
        end
        r.side = atlas_px[SIDE_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("item %0d: %s got %0d expected %0d", results_in, field, got, want);
        mismatches++;
    endtask

    // Offer one request, hold it until accepted, then queue its prediction
    task automatic offer_request(logic [REQ_W-1:0] req, logic [CODE_W-1:0] code,
                                 bit typed, glyph_t typed_val);
        glyph_t pred;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(IN_DATA_W-CODE_W){1'b0}}, code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = lookup_glyph(req, code);
        pending_glyphs.push_back(typed ? typed_val : pred);
        @(negedge clk);
    endtask

    // Write a register once the block has drained and is ready again
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_glyphs.size() != 0)
            @(negedge clk);
        repeat (24) @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_TILE_WIDTH)
            tile_w_reg = val & 14'h1FF;
        else if (idx == CFG_TILE_HEIGHT)
            tile_h_reg = val & 14'h1FF;
        else if (idx == CFG_ATLAS_SIZE)
        begin
            atlas_px = eff_side(val);
            wipe_map();
        end
    endtask

    // Drive m_tready: random stalls, a calm stretch and one long hold-off
    always @(negedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each returned item with the oldest prediction
    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_in++;
            if (pending_glyphs.size() == 0)
                report_mismatch("unexpected item, status", m_tuser, 0);
            else
            begin
                want = pending_glyphs.pop_front();
                if (m_tuser != want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[15:0] != want.slot)
                    report_mismatch("slot_index", m_tdata[15:0], want.slot);
                if (m_tdata[28:16] != want.px_x)
                    report_mismatch("rect_x", m_tdata[28:16], want.px_x);
                if (m_tdata[41:29] != want.px_y)
                    report_mismatch("rect_y", m_tdata[41:29], want.px_y);
                if (m_tdata[55:42] != want.side)
                    report_mismatch("atlas_size", m_tdata[55:42], want.side);
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        dir_row_t         row;
        phase_t           ph;
        glyph_t           typed_val;
        logic [REQ_W-1:0] req;
        logic [CODE_W-1:0] code;
        int unsigned      pick;

        // Reset values of the mirrored allocator
        tile_w_reg = TILE_RESET;
        tile_h_reg = TILE_RESET;
        atlas_px   = SIDE_RESET;
        wipe_map();

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < DIR_N; i++)
        begin
            row = DIR_ROWS[i];
            if (row.is_cfg)
                write_reg(row.sel, row.val[CFG_DATA_W-1:0]);
            else
            begin
                typed_val = '{status: row.st, slot: row.slot, px_x: row.px_x,
                              px_y: row.px_y, side: row.side};
                offer_request(row.sel, row.val, row.typed, typed_val);
            end
        end

        // Random phases, each under its own geometry
        typed_val = '{status: ST_HIT, slot: '0, px_x: '0, px_y: '0, side: '0};
        for (int p = 0; p < PHASE_N; p++)
        begin
            ph = PHASES[p];
            if (ph.wmask[0])
                write_reg(CFG_TILE_WIDTH, ph.tw);
            if (ph.wmask[1])
                write_reg(CFG_TILE_HEIGHT, ph.th);
            if (ph.wmask[2])
                write_reg(CFG_ATLAS_SIZE, ph.side);
            no_idle = (p == CALM_PH);
            if (p == PRESS_PH)
                hold_arm = 1'b1;
            for (int n = 0; n < ph.items; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < ph.rst_pct)
                    req = REQ_RESET;
                else if (pick < ph.rst_pct + SPARE_PCT)
                    req = REQ_SPARE;
                else if (pick < ph.rst_pct + SPARE_PCT + ph.ens_pct)
                    req = REQ_ENSURE;
                else
                    req = REQ_QUERY;
                if ($urandom_range(0, 99) < ph.oor_pct)
                    code = CODE_W'($urandom_range(MAP_DEPTH_DEF, CODE_MAX));
                else
                    code = CODE_W'($urandom_range(0, ph.window - 1));
                offer_request(req, code, 1'b0, typed_val);
            end
        end
        no_idle = 1'b0;

        // Drain, then allow a late stray item to show up
        s_tvalid <= 1'b0;
        while (pending_glyphs.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (mismatches == 0 && pending_glyphs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
